[rtl/sha_pkg.sv]
package sha_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;   // store an input byte into the block buffer
    logic pad_byte;    // store a padding byte (0x80 first, then zeros)
    logic put_len;     // write the bit count into words 14 and 15
    logic start_blk;   // copy hash words into working variables
    logic round;       // run one compression round
    logic update;      // add working variables into the hash words
    logic clear_msg;   // reset hash words, fill and bit count
  } dp_cmd_t;

  typedef struct packed {
    logic       block_full;  // a write at fill 63 completes the block
    logic [5:0] fill;
    logic       last_round;
    logic       pad_first;   // the 0x80 marker has not been written yet
  } dp_sts_t;

  localparam int unsigned NUM_DIGEST_WORDS = 8;
  localparam int unsigned NUM_ROUNDS = 64;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

endpackage

[rtl/sha_datapath.sv]
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  byte_in,
  input  logic [2:0]  rd_index,
  output dp_sts_t     sts,
  output logic [31:0] hash_word
);

  logic [31:0] hash_r [8];
  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [5:0]  rnd_r;
  logic        pad_first_r;

  logic [31:0] wt, x15, x2, s1, ch, t1, s0, mj, t2;
  logic [7:0]  wr_byte;
  logic        wr_en;

  always_comb begin
    x15 = w_r[1];
    x2  = w_r[14];
    if (rnd_r < 6'd16) begin
      wt = w_r[0];
    end else begin
      wt = w_r[0] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w_r[9]
         + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
    end
    s1 = ror32(v_r[4], 6) ^ ror32(v_r[4], 11) ^ ror32(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + ROUND_K[rnd_r] + wt;
    s0 = ror32(v_r[0], 2) ^ ror32(v_r[0], 13) ^ ror32(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + mj;
    wr_en   = cmd.load_byte | cmd.pad_byte;
    wr_byte = cmd.load_byte ? byte_in : (pad_first_r ? PAD_MARK : 8'h00);
  end

  assign sts.block_full = wr_en && (fill_r == 6'd63);
  assign sts.fill       = fill_r;
  assign sts.last_round = (rnd_r == 6'd63);
  assign sts.pad_first  = pad_first_r;
  assign hash_word      = hash_r[rd_index];

  // The schedule is a 16-word shift line; word 0 is Wt in rounds 0-15, later Wt is formed from words 0, 1, 9, 14.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_r[fill_r[5:2]] <= (fill_r[1:0] == 2'd0) ? {wr_byte, 24'h0}
        : (w_r[fill_r[5:2]] | ({24'h0, wr_byte} << ((2'd3 - fill_r[1:0]) * 8)));
    end else if (cmd.put_len) begin
      w_r[14] <= bits_r[63:32];
      w_r[15] <= bits_r[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wt;
    end
    if (cmd.start_blk) begin
      for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_msg) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= INIT_H[i];
      fill_r      <= '0;
      bits_r      <= '0;
      rnd_r       <= '0;
      pad_first_r <= 1'b1;
    end else begin
      if (wr_en) fill_r <= fill_r + 6'd1;
      if (cmd.load_byte) bits_r <= bits_r + 64'd8;
      if (cmd.pad_byte) pad_first_r <= 1'b0;
      if (cmd.start_blk) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.update) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
      end
    end
  end

endmodule

[rtl/sha_ctrl.sv]
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_index,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic       final_r, final_nxt;
  logic       len_r, len_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign acc = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          final_nxt = in_data.last_byte;
          len_nxt   = 1'b0;
          if (in_data.byte_present && sts.block_full) state_nxt = ST_ROUND;
          else if (in_data.last_byte) state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (sts.block_full) begin
          state_nxt = ST_ROUND;
        end else if (sts.fill == LEN_START && !len_r && !sts.pad_first) begin
          len_nxt   = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (sts.last_round) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!final_r) state_nxt = ST_IDLE;
        else if (len_r) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end else state_nxt = ST_PAD;
      end
      ST_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = ST_IDLE;
            final_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs. A write at fill 63 completes the block.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_index = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_byte = acc && in_data.byte_present;
        cmd.start_blk = acc && in_data.byte_present && (sts.fill == 6'd63);
      end
      ST_PAD: begin
        if (sts.fill == LEN_START && !len_r && !sts.pad_first) begin
          cmd.put_len   = 1'b1;
          cmd.start_blk = 1'b1;
        end else begin
          cmd.pad_byte  = 1'b1;
          cmd.start_blk = (sts.fill == 6'd63);
        end
      end
      ST_ROUND:  cmd.round = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.clear_msg = out_ready && (idx_r == 3'd7);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
      len_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[rtl/sha256_hash_engine.sv]
// SHA-256 engine fed one message byte per input word.
// Input channel (in_valid/in_ready/in_data): each word carries a byte, a
// byte-present flag and a last flag. Bytes are packed big-endian into a
// 64-byte block buffer; a word with no byte and no last flag does nothing.
// An ordinary byte leaves in_ready high. The byte that completes a block
// starts a compression of 64 rounds and then the hash update, and in_ready
// stays low until the update is done; the round loop paces it.
// A word flagged last appends padding one byte per cycle (pausing while a
// full block compresses) up to position 56, loads the bit count and
// compresses; if 56 or more bytes were buffered a second block follows.
// The digest then leaves on the output channel as eight words, index 0
// first, the eighth flagged last_word. Output words are held stable while
// out_ready is low; the engine waits, and takes no input until the eighth
// word is accepted, then restarts with the initial hash values.
// Reset (rst_n low, synchronous) loads the initial hash values and empties
// the buffer and bit count; no clearing pass is needed.
module sha256_hash_engine
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [2:0]  idx;
  logic [31:0] hword;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_index(idx), .sts(sts), .cmd(cmd)
  );

  sha_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .byte_in(in_data.message_byte),
    .rd_index(idx), .sts(sts), .hash_word(hword)
  );

  // The digest words are read straight from the hash registers, which hold
  // still while the result is pending.
  assign out_data.digest_word = hword;
  assign out_data.word_index  = idx;
  assign out_data.last_word   = (idx == 3'd7);

endmodule

[rtl/sha_checker.sv]
module sha_checker
  import sha_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while digest pending");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest word changed under stall");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest words not consecutive");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word mismatch");

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
